// File: rtl/ehta_pkg.sv
package ehta_pkg;

    localparam int COUNT_W = 32;
    localparam int TIME_W  = 48;
    localparam int QUERY_W = 4;

    typedef enum logic
    {
        OP_EPOCH = 1'b0,
        OP_HINT  = 1'b1
    } op_t;

    typedef struct packed
    {
        logic [COUNT_W-1:0] epoch_count_out;
        logic [TIME_W-1:0]  last_runtime;
        logic               runtime_valid;
        logic [TIME_W-1:0]  hint_runtime;
        logic               hint_runtime_valid;
        logic               bad_category;
    } result_t;

endpackage

// File: rtl/epoch_hint_time_accumulator.sv
// Epoch / hint time accumulator.
// Input channel (in_valid/in_ready) carries one event per beat: an epoch
// marker (operation 0, event_value = epoch count) or a hint change
// (operation 1, event_value = category). Elapsed ticks are charged to the
// active category; each epoch marker records the runtime since the previous
// marker, snapshots the per-category totals from the second marker on, and
// clears the running totals. Totals saturate at all ones.
// Output channel (out_valid/out_ready) returns one result beat per event:
// epoch count, last runtime, snapshot total for query_hint, valid flags and
// a bad-category flag.
// Each result is registered, in the skid register if a result still waits.
// Throughput: one event per cycle while in_ready is high; two subtracts, one
// saturating add and a category select lie between state and result regs.
// Stall: a two-entry output stage (result register plus skid register) lets
// one more event in while a result waits; in_ready drops only when both are
// full, and rises again as soon as the receiver takes a beat.
// Reset: rst_n clears all state, totals and snapshots, and empties the output
// stage; in_ready is high, so the block takes events as soon as reset ends.
module epoch_hint_time_accumulator
    import ehta_pkg::*;
#(
    parameter int NUM_CATEGORIES = 8,
    parameter int TIME_BITS      = 48
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic [TIME_W-1:0]  event_time,
    input  logic [COUNT_W-1:0] event_value,
    input  logic [QUERY_W-1:0] query_hint,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COUNT_W-1:0] epoch_count_out,
    output logic [TIME_W-1:0]  last_runtime,
    output logic               runtime_valid,
    output logic [TIME_W-1:0]  hint_runtime,
    output logic               hint_runtime_valid,
    output logic               bad_category
);

    localparam int CW = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
    localparam int TW = TIME_BITS;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TW-1:0]      prev_time_reg, prev_time_next;
    logic               prev_seen_reg, prev_seen_next;
    logic [TW-1:0]      runtime_reg, runtime_next;
    logic               runtime_seen_reg, runtime_seen_next;
    logic [CW-1:0]      active_cat_reg, active_cat_next;
    logic               active_bad_reg, active_bad_next;
    logic [TW-1:0]      change_time_reg, change_time_next;
    logic               change_seen_reg, change_seen_next;
    logic [TW-1:0]      running_reg [NUM_CATEGORIES];
    logic [TW-1:0]      running_next [NUM_CATEGORIES];
    logic [TW-1:0]      snap_reg [NUM_CATEGORIES];
    logic [TW-1:0]      snap_next [NUM_CATEGORIES];
    logic               snap_seen_reg, snap_seen_next;

    logic [TW-1:0]      t_now;
    logic [TW:0]        charge_diff;
    logic [TW-1:0]      charge_elapsed;
    logic [TW:0]        charge_sum;
    logic [TW-1:0]      charge_total;
    logic               charge_en;
    logic [TW:0]        epoch_diff;
    logic [TW-1:0]      charged [NUM_CATEGORIES];
    logic               query_ok;
    logic               value_bad;

    result_t            res_next;
    result_t            out_data_reg, out_data_next;
    result_t            skid_data_reg, skid_data_next;
    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    logic               in_fire;
    logic               out_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    always_comb
    begin
        t_now          = TW'(event_time);
        charge_diff    = {1'b0, t_now} - {1'b0, change_time_reg};
        charge_elapsed = charge_diff[TW] ? '0 : charge_diff[TW-1:0];
        charge_sum     = {1'b0, running_reg[active_cat_reg]} + {1'b0, charge_elapsed};
        charge_total   = charge_sum[TW] ? '1 : charge_sum[TW-1:0];
        charge_en      = change_seen_reg && !active_bad_reg;
        epoch_diff     = {1'b0, t_now} - {1'b0, prev_time_reg};
        query_ok       = 32'(query_hint) < 32'(NUM_CATEGORIES);
        value_bad      = event_value >= COUNT_W'(NUM_CATEGORIES);

        for (int i = 0; i < NUM_CATEGORIES; i++)
        begin
            charged[i] = (charge_en && active_cat_reg == CW'(i)) ? charge_total
                                                                 : running_reg[i];
        end

        count_next        = count_reg;
        prev_time_next    = prev_time_reg;
        prev_seen_next    = prev_seen_reg;
        runtime_next      = runtime_reg;
        runtime_seen_next = runtime_seen_reg;
        active_cat_next   = active_cat_reg;
        active_bad_next   = active_bad_reg;
        change_time_next  = t_now;
        change_seen_next  = 1'b1;
        snap_seen_next    = snap_seen_reg;
        for (int i = 0; i < NUM_CATEGORIES; i++)
        begin
            running_next[i] = charged[i];
            snap_next[i]    = snap_reg[i];
        end

        if (op_t'(operation) == OP_EPOCH)
        begin
            count_next     = event_value;
            prev_time_next = t_now;
            prev_seen_next = 1'b1;
            if (prev_seen_reg)
            begin
                runtime_next      = epoch_diff[TW] ? '0 : epoch_diff[TW-1:0];
                runtime_seen_next = 1'b1;
            end
            for (int i = 0; i < NUM_CATEGORIES; i++)
            begin
                running_next[i] = '0;
                if (runtime_seen_next)
                begin
                    snap_next[i] = charged[i];
                end
            end
            if (runtime_seen_next)
            begin
                snap_seen_next = 1'b1;
            end
        end
        else
        begin
            active_bad_next = value_bad;
            active_cat_next = value_bad ? '0 : event_value[CW-1:0];
        end

        res_next.epoch_count_out    = count_next;
        res_next.last_runtime       = TIME_W'(runtime_next);
        res_next.runtime_valid      = runtime_seen_next;
        res_next.hint_runtime_valid = snap_seen_next && query_ok;
        res_next.hint_runtime       = res_next.hint_runtime_valid
                                      ? TIME_W'(snap_next[query_hint[CW-1:0]]) : '0;
        res_next.bad_category       = !query_ok
                                      || (op_t'(operation) == OP_HINT && value_bad);
    end

    always_comb
    begin
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_valid_next = skid_valid_reg;
        if (out_fire)
        begin
            out_valid_next = skid_valid_reg;
            out_data_next  = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_data_next  = res_next;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = res_next;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            prev_time_reg    <= '0;
            prev_seen_reg    <= 1'b0;
            runtime_reg      <= '0;
            runtime_seen_reg <= 1'b0;
            active_cat_reg   <= '0;
            active_bad_reg   <= 1'b0;
            change_time_reg  <= '0;
            change_seen_reg  <= 1'b0;
            snap_seen_reg    <= 1'b0;
            for (int i = 0; i < NUM_CATEGORIES; i++)
            begin
                running_reg[i] <= '0;
                snap_reg[i]    <= '0;
            end
        end
        else if (in_fire)
        begin
            count_reg        <= count_next;
            prev_time_reg    <= prev_time_next;
            prev_seen_reg    <= prev_seen_next;
            runtime_reg      <= runtime_next;
            runtime_seen_reg <= runtime_seen_next;
            active_cat_reg   <= active_cat_next;
            active_bad_reg   <= active_bad_next;
            change_time_reg  <= change_time_next;
            change_seen_reg  <= change_seen_next;
            snap_seen_reg    <= snap_seen_next;
            for (int i = 0; i < NUM_CATEGORIES; i++)
            begin
                running_reg[i] <= running_next[i];
                snap_reg[i]    <= snap_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid          = out_valid_reg;
    assign epoch_count_out    = out_data_reg.epoch_count_out;
    assign last_runtime       = out_data_reg.last_runtime;
    assign runtime_valid      = out_data_reg.runtime_valid;
    assign hint_runtime       = out_data_reg.hint_runtime;
    assign hint_runtime_valid = out_data_reg.hint_runtime_valid;
    assign bad_category       = out_data_reg.bad_category;

endmodule

// File: rtl/ehta_checker.sv
module ehta_checker
    import ehta_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [COUNT_W-1:0] epoch_count_out,
    input logic [TIME_W-1:0]  last_runtime,
    input logic               runtime_valid,
    input logic [TIME_W-1:0]  hint_runtime,
    input logic               hint_runtime_valid,
    input logic               bad_category
);

    logic rt_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_seen_reg <= 1'b0;
        end
        else if (out_valid && out_ready && runtime_valid)
        begin
            rt_seen_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
        && $stable({epoch_count_out, last_runtime, runtime_valid,
                    hint_runtime, hint_runtime_valid, bad_category}))
        else $error("output beat changed while stalled");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input held off with no result pending");

    a_runtime_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rt_seen_reg |-> runtime_valid)
        else $error("runtime valid fell after being reported");

    a_snapshot_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hint_runtime_valid |-> runtime_valid)
        else $error("snapshot total reported before any runtime");

    a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hint_runtime_valid |-> hint_runtime == '0
        && (runtime_valid || last_runtime == '0))
        else $error("time field not zero while its valid flag is low");

endmodule

bind epoch_hint_time_accumulator ehta_checker u_ehta_checker (.*);

// File: verif/tb_epoch_hint_time_accumulator.sv
module tb_epoch_hint_time_accumulator
    import ehta_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_CAT        = 8;
    localparam int RANDOM_ITEMS = 1550;
    localparam int STALL_LIMIT  = 1000;
    localparam logic [TIME_W-1:0] TICK_MAX = '1;

    typedef struct {
        op_t                op;
        logic [TIME_W-1:0]  stamp;
        logic [COUNT_W-1:0] value;
        logic [QUERY_W-1:0] query;
    } event_beat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               operation = 1'b0;
    logic [TIME_W-1:0]  event_time = '0;
    logic [COUNT_W-1:0] event_value = '0;
    logic [QUERY_W-1:0] query_hint = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [COUNT_W-1:0] epoch_count_out;
    logic [TIME_W-1:0]  last_runtime;
    logic               runtime_valid;
    logic [TIME_W-1:0]  hint_runtime;
    logic               hint_runtime_valid;
    logic               bad_category;

    event_beat_t pending_events[$];
    event_beat_t held;
    result_t     due_results[$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          launched = 0;
    int          taken = 0;

    // predictor state
    logic [COUNT_W-1:0] epoch_count_q = '0;
    logic [TIME_W-1:0]  prev_mark_time = '0;
    logic               prev_mark_seen = 1'b0;
    logic [TIME_W-1:0]  runtime_q = '0;
    logic               runtime_seen_q = 1'b0;
    logic [2:0]         active_cat = '0;
    logic               active_cat_bad = 1'b0;
    logic [TIME_W-1:0]  change_time = '0;
    logic               change_seen = 1'b0;
    logic [TIME_W-1:0]  running_ticks [N_CAT] = '{default: '0};
    logic [TIME_W-1:0]  snapshot_ticks [N_CAT] = '{default: '0};
    logic               snapshot_seen_q = 1'b0;

    epoch_hint_time_accumulator u_dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .operation          (operation),
        .event_time         (event_time),
        .event_value        (event_value),
        .query_hint         (query_hint),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .epoch_count_out    (epoch_count_out),
        .last_runtime       (last_runtime),
        .runtime_valid      (runtime_valid),
        .hint_runtime       (hint_runtime),
        .hint_runtime_valid (hint_runtime_valid),
        .bad_category       (bad_category)
    );

    always #6 clk = ~clk;

    function automatic logic [TIME_W-1:0] ticks_since(logic [TIME_W-1:0] now,
                                                      logic [TIME_W-1:0] then);
        return (now >= then) ? now - then : '0;
    endfunction

    function automatic void charge_active(logic [TIME_W-1:0] now);
        logic [TIME_W:0] sum;
        if (change_seen && !active_cat_bad)
        begin
            sum = {1'b0, running_ticks[active_cat]} + {1'b0, ticks_since(now, change_time)};
            running_ticks[active_cat] = sum[TIME_W] ? TICK_MAX : sum[TIME_W-1:0];
        end
    endfunction

    function automatic result_t account_event(event_beat_t ev);
        result_t r;
        logic    flag;
        flag = (ev.query >= N_CAT);
        if (ev.op == OP_EPOCH)
        begin
            epoch_count_q = ev.value;
            if (prev_mark_seen)
            begin
                runtime_q      = ticks_since(ev.stamp, prev_mark_time);
                runtime_seen_q = 1'b1;
            end
            prev_mark_time = ev.stamp;
            prev_mark_seen = 1'b1;
            charge_active(ev.stamp);
            change_time = ev.stamp;
            change_seen = 1'b1;
            if (runtime_seen_q)
            begin
                snapshot_ticks  = running_ticks;
                snapshot_seen_q = 1'b1;
            end
            foreach (running_ticks[i])
                running_ticks[i] = '0;
        end
        else
        begin
            charge_active(ev.stamp);
            if (ev.value >= N_CAT)
            begin
                active_cat_bad = 1'b1;
                active_cat     = '0;
                flag           = 1'b1;
            end
            else
            begin
                active_cat_bad = 1'b0;
                active_cat     = ev.value[2:0];
            end
            change_time = ev.stamp;
            change_seen = 1'b1;
        end
        r.epoch_count_out = epoch_count_q;
        r.last_runtime    = runtime_seen_q ? runtime_q : '0;
        r.runtime_valid   = runtime_seen_q;
        if (snapshot_seen_q && ev.query < N_CAT)
        begin
            r.hint_runtime       = snapshot_ticks[ev.query[2:0]];
            r.hint_runtime_valid = 1'b1;
        end
        else
        begin
            r.hint_runtime       = '0;
            r.hint_runtime_valid = 1'b0;
        end
        r.bad_category = flag;
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic queue_event(op_t op, logic [TIME_W-1:0] stamp,
                               logic [COUNT_W-1:0] value, logic [QUERY_W-1:0] query);
        event_beat_t ev;
        ev.op    = op;
        ev.stamp = stamp;
        ev.value = value;
        ev.query = query;
        pending_events.push_back(ev);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        logic calm;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            calm = (launched >= 650 && launched < 950);
            if (pending_events.size() != 0 && (calm || $urandom_range(0, 99) >= 34))
            begin
                held = pending_events.pop_front();
                launched++;
                operation   <= held.op;
                event_time  <= held.stamp;
                event_value <= held.value;
                query_hint  <= held.query;
                in_valid    <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor: check the result beat first, then predict the accepted event
    always @(posedge clk or negedge rst_n)
    begin
        result_t     want;
        event_beat_t seen;
        logic        calm;
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result beat with no event pending");
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("epoch_count_out", 64'(want.epoch_count_out),
                                64'(epoch_count_out));
                    check_field("last_runtime", 64'(want.last_runtime), 64'(last_runtime));
                    check_field("runtime_valid", 64'(want.runtime_valid),
                                64'(runtime_valid));
                    check_field("hint_runtime", 64'(want.hint_runtime), 64'(hint_runtime));
                    check_field("hint_runtime_valid", 64'(want.hint_runtime_valid),
                                64'(hint_runtime_valid));
                    check_field("bad_category", 64'(want.bad_category), 64'(bad_category));
                end
            end
            if (in_valid && in_ready)
            begin
                seen.op    = op_t'(operation);
                seen.stamp = event_time;
                seen.value = event_value;
                seen.query = query_hint;
                due_results.push_back(account_event(seen));
                taken++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            calm = (taken >= 650 && taken < 950);
            out_ready <= calm || ($urandom_range(0, 99) >= 34);
        end
    end

    initial
    begin
        logic [TIME_W-1:0]  now_ticks;
        logic [TIME_W-1:0]  stamp;
        logic [COUNT_W-1:0] value;
        logic [QUERY_W-1:0] query;
        logic [COUNT_W-1:0] mark_count;
        int                 pick;
        op_t                op;

        queue_event(OP_HINT, 48'd100, 32'd5, 4'd0);
        queue_event(OP_EPOCH, '0, 32'd0, 4'd15);
        queue_event(OP_EPOCH, '0, 32'hFFFF_FFFF, 4'd0);
        queue_event(OP_HINT, '0, 32'd3, 4'd8);
        queue_event(OP_HINT, TICK_MAX, 32'd3, 4'd3);
        queue_event(OP_HINT, '0, 32'd3, 4'd3);
        queue_event(OP_HINT, TICK_MAX, 32'd3, 4'd3);
        queue_event(OP_HINT, TICK_MAX, 32'd8, 4'd1);
        queue_event(OP_HINT, TICK_MAX, 32'hFFFF_FFFF, 4'd2);
        queue_event(OP_EPOCH, TICK_MAX, 32'd1, 4'd3);
        queue_event(OP_EPOCH, TICK_MAX, 32'd2, 4'd3);
        queue_event(OP_EPOCH, 48'd10, 32'h5555_5555, 4'd7);
        for (int c = 0; c < N_CAT; c++)
            queue_event(OP_HINT, 48'd20 + 48'd20 * c * (c + 1), c, 4'(c));
        queue_event(OP_EPOCH, 48'd2000, 32'hAAAA_AAAA, 4'd0);
        queue_event(OP_HINT, 48'd2100, 32'd1, 4'd1);
        queue_event(OP_HINT, 48'd2200, 32'd2, 4'd4);
        queue_event(OP_HINT, 48'd2300, 32'd9, 4'd6);
        queue_event(OP_HINT, 48'd2400, 32'd7, 4'd7);

        now_ticks  = 48'd2400;
        mark_count = 32'd3;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                stamp = now_ticks + $urandom_range(0, 5000);
            else if (pick < 86)
                stamp = now_ticks;
            else if (pick < 91)
                stamp = now_ticks - $urandom_range(1, 1000);
            else if (pick < 96)
                stamp = TIME_W'({$urandom, $urandom});
            else
                stamp = TICK_MAX - $urandom_range(0, 100000);
            now_ticks = stamp;

            if ($urandom_range(0, 99) < 12)
            begin
                op = OP_EPOCH;
                mark_count++;
                value = ($urandom_range(0, 3) == 0) ? $urandom : mark_count;
            end
            else
            begin
                op = OP_HINT;
                pick = $urandom_range(0, 99);
                if (pick < 88)
                    value = $urandom_range(0, N_CAT - 1);
                else if (pick < 94)
                    value = $urandom_range(N_CAT, 15);
                else
                    value = $urandom;
            end
            query = ($urandom_range(0, 99) < 85) ? QUERY_W'($urandom_range(0, N_CAT - 1))
                                                 : QUERY_W'($urandom_range(N_CAT, 15));
            queue_event(op, stamp, value, query);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while ((pending_events.size() != 0 || in_valid || due_results.size() != 0)
               && quiet_cycles < STALL_LIMIT)
            @(negedge clk);
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $error("no beat accepted for %0d cycles", STALL_LIMIT);
            mismatches++;
        end
        else
        begin
            repeat (8) @(negedge clk);
            if (due_results.size() != 0)
            begin
                $error("%0d results never arrived", due_results.size());
                mismatches++;
            end
        end

        if (mismatches == 0)
            $display("tb_epoch_hint_time_accumulator: clean");
        else
            $display("tb_epoch_hint_time_accumulator: errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/ehta_pkg.sv
rtl/epoch_hint_time_accumulator.sv
rtl/ehta_checker.sv
verif/tb_epoch_hint_time_accumulator.sv
